// File: src/mm160_pkg.sv
// ----------------------------------------------------------------------------
// mm160_pkg
// Shared types, constants and microcode encodings for the 160-bit
// five-lane MurmurHash2 engine.
// ----------------------------------------------------------------------------
package mm160_pkg;

  localparam int unsigned LANES  = 5;
  localparam int unsigned LANE_W = 3;
  localparam int unsigned PC_W   = 5;

  localparam logic [PC_W-1:0] PC_MIX  = 5'd0;
  localparam logic [PC_W-1:0] PC_TAIL = 5'd8;
  localparam logic [PC_W-1:0] PC_FIN  = 5'd14;

  localparam logic [31:0] MUL0 = 32'h5bd1e995;
  localparam logic [31:0] MUL1 = 32'h19D699A5;
  localparam logic [31:0] MUL2 = 32'hB11924E1;
  localparam logic [31:0] MUL3 = 32'h16118B03;
  localparam logic [31:0] MUL4 = 32'h53C93455;

  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_WORD,
    SRC_KMIX,
    SRC_LANE,
    SRC_TAIL,
    SRC_FIN
  } mul_src_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_K,
    WB_MIX,
    WB_PLAIN,
    WB_FIN
  } wb_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_END,
    SEQ_BRANCH,
    SEQ_EMIT
  } seq_op_t;

  typedef struct packed {
    mul_src_t          mul_src;
    logic [LANE_W-1:0] mul_lane;
    wb_op_t            wb_op;
    logic [LANE_W-1:0] wb_lane;
    seq_op_t           seq_op;
  } ucode_t;

  localparam ucode_t CTRL_NOP = '{SRC_NONE, 3'd0, WB_NONE, 3'd0, SEQ_END};

  typedef struct packed {
    logic        start;
    logic        first;
    logic [31:0] word;
    logic [31:0] tail;
    logic [31:0] base;
  } load_t;

  typedef struct packed {
    logic [31:0] hash_word0;
    logic [31:0] hash_word1;
    logic [31:0] hash_word2;
    logic [31:0] hash_word3;
    logic [31:0] hash_word4;
    logic [31:0] folded_hash;
  } hash_t;

  function automatic logic [31:0] lane_mul(input logic [LANE_W-1:0] idx);
    logic [31:0] m;
    unique case (idx)
      3'd0:    m = MUL0;
      3'd1:    m = MUL1;
      3'd2:    m = MUL2;
      3'd3:    m = MUL3;
      3'd4:    m = MUL4;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

// File: src/murmur2_160_hash_top.sv
// ----------------------------------------------------------------------------
// murmur2_160_hash_top
// 160-bit five-lane MurmurHash2 engine with an APB seed register.
//
// A message is sent as requests on the input channel, one little-endian
// 32-bit word per request. The first request carries the total length in
// bytes and starts the five lanes from seed XOR length. The last request
// may hold one to three tail bytes; it produces one request on the output
// channel with the five hash words and their XOR fold. Requests that are
// neither first nor inside an open message are taken and dropped.
// The engine works on one request at a time on a single shared multiplier,
// run by a microcoded step counter; the input stays not ready until the
// counter has finished the current request. A last request runs the mix
// program for a full word, the tail program for tail bytes or neither,
// then the finalisation program and the emit step. The result
// sits in an output register, so the next message can start while it waits;
// only a second result stalls the engine on its emit step until the
// receiver takes the first.
// Reset clears the seed, closes any open message and empties the output.
// ----------------------------------------------------------------------------
module murmur2_160_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [31:0] message_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_word0,
  output logic [31:0] hash_word1,
  output logic [31:0] hash_word2,
  output logic [31:0] hash_word3,
  output logic [31:0] hash_word4,
  output logic [31:0] folded_hash
);

  logic                       seed;
  logic [31:0]                seed_reg;
  logic                       in_message;
  logic                       accept;
  logic                       busy;
  logic                       emit;
  logic                       out_free;
  logic [31:0]                tail_mask;
  logic [mm160_pkg::PC_W-1:0] entry;
  mm160_pkg::load_t           load;
  mm160_pkg::ucode_t          ctrl;
  mm160_pkg::hash_t           hash;
  mm160_pkg::hash_t           result;

  assign pready = 1'b1;
  assign seed   = (paddr[2] == 1'b0);
  assign prdata = seed ? seed_reg : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= 32'd0;
    end else if (psel && penable && pwrite && seed) begin
      seed_reg <= pwdata;
    end
  end

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    unique case (byte_count)
      3'd1:    tail_mask = 32'h0000_00FF;
      3'd2:    tail_mask = 32'h0000_FFFF;
      3'd3:    tail_mask = 32'h00FF_FFFF;
      default: tail_mask = 32'd0;
    endcase
  end

  always_comb begin
    priority if (!last_item || byte_count >= 3'd4) begin
      entry = mm160_pkg::PC_MIX;
    end else if (byte_count != 3'd0) begin
      entry = mm160_pkg::PC_TAIL;
    end else begin
      entry = mm160_pkg::PC_FIN;
    end
  end

  assign load.start = accept && (first_item || in_message);
  assign load.first = first_item;
  assign load.word  = data_word;
  assign load.tail  = data_word & tail_mask;
  assign load.base  = seed_reg ^ message_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else if (load.start) begin
      in_message <= !last_item;
    end
  end

  mm160_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (load.start),
    .start_last (last_item),
    .entry      (entry),
    .out_free   (out_free),
    .busy       (busy),
    .emit       (emit),
    .ctrl       (ctrl)
  );

  mm160_datapath u_dp (
    .clk  (clk),
    .load (load),
    .ctrl (ctrl),
    .hash (hash)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= hash;
    end
  end

  assign hash_word0  = result.hash_word0;
  assign hash_word1  = result.hash_word1;
  assign hash_word2  = result.hash_word2;
  assign hash_word3  = result.hash_word3;
  assign hash_word4  = result.hash_word4;
  assign folded_hash = result.folded_hash;

endmodule

// File: src/mm160_ucode_rom.sv
// ----------------------------------------------------------------------------
// mm160_ucode_rom
// Control store: one control word per step of the mix, tail and
// finalisation programs.
// ----------------------------------------------------------------------------
module mm160_ucode_rom (
  input  logic [mm160_pkg::PC_W-1:0] pc,
  output mm160_pkg::ucode_t          ctrl
);

  always_comb begin
    unique case (pc)
      5'd0:  ctrl = '{mm160_pkg::SRC_WORD, 3'd0, mm160_pkg::WB_NONE,  3'd0, mm160_pkg::SEQ_NEXT};
      5'd1:  ctrl = '{mm160_pkg::SRC_KMIX, 3'd0, mm160_pkg::WB_NONE,  3'd0, mm160_pkg::SEQ_NEXT};
      5'd2:  ctrl = '{mm160_pkg::SRC_LANE, 3'd0, mm160_pkg::WB_K,     3'd0, mm160_pkg::SEQ_NEXT};
      5'd3:  ctrl = '{mm160_pkg::SRC_LANE, 3'd1, mm160_pkg::WB_MIX,   3'd0, mm160_pkg::SEQ_NEXT};
      5'd4:  ctrl = '{mm160_pkg::SRC_LANE, 3'd2, mm160_pkg::WB_MIX,   3'd1, mm160_pkg::SEQ_NEXT};
      5'd5:  ctrl = '{mm160_pkg::SRC_LANE, 3'd3, mm160_pkg::WB_MIX,   3'd2, mm160_pkg::SEQ_NEXT};
      5'd6:  ctrl = '{mm160_pkg::SRC_LANE, 3'd4, mm160_pkg::WB_MIX,   3'd3, mm160_pkg::SEQ_NEXT};
      5'd7:  ctrl = '{mm160_pkg::SRC_NONE, 3'd0, mm160_pkg::WB_MIX,   3'd4, mm160_pkg::SEQ_BRANCH};
      5'd8:  ctrl = '{mm160_pkg::SRC_TAIL, 3'd0, mm160_pkg::WB_NONE,  3'd0, mm160_pkg::SEQ_NEXT};
      5'd9:  ctrl = '{mm160_pkg::SRC_TAIL, 3'd1, mm160_pkg::WB_PLAIN, 3'd0, mm160_pkg::SEQ_NEXT};
      5'd10: ctrl = '{mm160_pkg::SRC_TAIL, 3'd2, mm160_pkg::WB_PLAIN, 3'd1, mm160_pkg::SEQ_NEXT};
      5'd11: ctrl = '{mm160_pkg::SRC_TAIL, 3'd3, mm160_pkg::WB_PLAIN, 3'd2, mm160_pkg::SEQ_NEXT};
      5'd12: ctrl = '{mm160_pkg::SRC_TAIL, 3'd4, mm160_pkg::WB_PLAIN, 3'd3, mm160_pkg::SEQ_NEXT};
      5'd13: ctrl = '{mm160_pkg::SRC_NONE, 3'd0, mm160_pkg::WB_PLAIN, 3'd4, mm160_pkg::SEQ_NEXT};
      5'd14: ctrl = '{mm160_pkg::SRC_FIN,  3'd0, mm160_pkg::WB_NONE,  3'd0, mm160_pkg::SEQ_NEXT};
      5'd15: ctrl = '{mm160_pkg::SRC_FIN,  3'd1, mm160_pkg::WB_FIN,   3'd0, mm160_pkg::SEQ_NEXT};
      5'd16: ctrl = '{mm160_pkg::SRC_FIN,  3'd2, mm160_pkg::WB_FIN,   3'd1, mm160_pkg::SEQ_NEXT};
      5'd17: ctrl = '{mm160_pkg::SRC_FIN,  3'd3, mm160_pkg::WB_FIN,   3'd2, mm160_pkg::SEQ_NEXT};
      5'd18: ctrl = '{mm160_pkg::SRC_FIN,  3'd4, mm160_pkg::WB_FIN,   3'd3, mm160_pkg::SEQ_NEXT};
      5'd19: ctrl = '{mm160_pkg::SRC_NONE, 3'd0, mm160_pkg::WB_FIN,   3'd4, mm160_pkg::SEQ_NEXT};
      5'd20: ctrl = '{mm160_pkg::SRC_NONE, 3'd0, mm160_pkg::WB_NONE,  3'd0, mm160_pkg::SEQ_EMIT};
      default: ctrl = mm160_pkg::CTRL_NOP;
    endcase
  end

endmodule

// File: src/mm160_datapath.sv
// ----------------------------------------------------------------------------
// mm160_datapath
// Five lane registers, the mixed-word register and one shared 32x32
// multiplier with a registered product, steered by the control word.
// ----------------------------------------------------------------------------
module mm160_datapath (
  input  logic               clk,
  input  mm160_pkg::load_t   load,
  input  mm160_pkg::ucode_t  ctrl,
  output mm160_pkg::hash_t   hash
);

  logic [31:0] lane [mm160_pkg::LANES];
  logic [31:0] word;
  logic [31:0] tail;
  logic [31:0] prod;
  logic [31:0] kmix;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_lo;
  logic [31:0] lane_rd;
  logic [31:0] lane_nx;
  logic [mm160_pkg::LANE_W-1:0] nx_idx;
  logic [31:0] wb_val;

  function automatic logic [31:0] pick(input logic [31:0] l0, input logic [31:0] l1,
                                       input logic [31:0] l2, input logic [31:0] l3,
                                       input logic [31:0] l4,
                                       input logic [mm160_pkg::LANE_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0:    v = l0;
      3'd1:    v = l1;
      3'd2:    v = l2;
      3'd3:    v = l3;
      3'd4:    v = l4;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  assign lane_rd = pick(lane[0], lane[1], lane[2], lane[3], lane[4], ctrl.mul_lane);
  assign nx_idx  = (ctrl.wb_lane >= 3'd4) ? 3'd0 : ctrl.wb_lane + 3'd1;
  assign lane_nx = pick(lane[0], lane[1], lane[2], lane[3], lane[4], nx_idx);

  always_comb begin
    unique case (ctrl.mul_src)
      mm160_pkg::SRC_WORD: mul_a = word;
      mm160_pkg::SRC_KMIX: mul_a = prod ^ (prod >> mm160_pkg::MIX_SHIFT);
      mm160_pkg::SRC_LANE: mul_a = lane_rd;
      mm160_pkg::SRC_TAIL: mul_a = lane_rd ^ tail;
      mm160_pkg::SRC_FIN:  mul_a = lane_rd ^ (lane_rd >> mm160_pkg::FIN_SHIFT_A);
      default:             mul_a = 32'd0;
    endcase
  end

  assign mul_b  = mm160_pkg::lane_mul(ctrl.mul_lane);
  assign mul_lo = mul_a * mul_b;

  always_comb begin
    unique case (ctrl.wb_op)
      mm160_pkg::WB_MIX:   wb_val = prod ^ kmix ^ lane_nx;
      mm160_pkg::WB_FIN:   wb_val = prod ^ (prod >> mm160_pkg::FIN_SHIFT_B);
      default:             wb_val = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_lo;
    if (ctrl.wb_op == mm160_pkg::WB_K) begin
      kmix <= prod;
    end
    if (load.start) begin
      word <= load.word;
      tail <= load.tail;
      if (load.first) begin
        lane[0] <= load.base;
        lane[1] <= load.base ^ mm160_pkg::MUL1;
        lane[2] <= load.base ^ mm160_pkg::MUL2;
        lane[3] <= load.base ^ mm160_pkg::MUL3;
        lane[4] <= load.base ^ mm160_pkg::MUL4;
      end
    end else if (ctrl.wb_op == mm160_pkg::WB_MIX || ctrl.wb_op == mm160_pkg::WB_PLAIN ||
                 ctrl.wb_op == mm160_pkg::WB_FIN) begin
      if (ctrl.wb_lane < 3'd5) begin
        lane[ctrl.wb_lane] <= wb_val;
      end
    end
  end

  always_comb begin
    hash.hash_word0  = lane[0] ^ lane[1] ^ lane[2] ^ lane[3] ^ lane[4];
    hash.hash_word1  = lane[1] ^ lane[0];
    hash.hash_word2  = lane[2] ^ lane[0];
    hash.hash_word3  = lane[3] ^ lane[0];
    hash.hash_word4  = lane[4] ^ lane[0];
    hash.folded_hash = hash.hash_word0 ^ hash.hash_word1 ^ hash.hash_word2 ^
                       hash.hash_word3 ^ hash.hash_word4;
  end

endmodule

// File: src/mm160_sequencer.sv
// ----------------------------------------------------------------------------
// mm160_sequencer
// Step counter over the control store, with the branch from mixing into
// finalisation and the hold on the emit step while the output is full.
// ----------------------------------------------------------------------------
module mm160_sequencer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       start_last,
  input  logic [mm160_pkg::PC_W-1:0] entry,
  input  logic                       out_free,
  output logic                       busy,
  output logic                       emit,
  output mm160_pkg::ucode_t          ctrl
);

  logic [mm160_pkg::PC_W-1:0] pc;
  logic                       last;
  mm160_pkg::ucode_t          rom_word;

  mm160_ucode_rom u_rom (
    .pc   (pc),
    .ctrl (rom_word)
  );

  assign ctrl = busy ? rom_word : mm160_pkg::CTRL_NOP;
  assign emit = busy && (rom_word.seq_op == mm160_pkg::SEQ_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
      last <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= entry;
      last <= start_last;
    end else if (busy) begin
      unique case (rom_word.seq_op)
        mm160_pkg::SEQ_NEXT: pc <= pc + 5'd1;
        mm160_pkg::SEQ_END:  busy <= 1'b0;
        mm160_pkg::SEQ_BRANCH: begin
          if (last) begin
            pc <= mm160_pkg::PC_FIN;
          end else begin
            busy <= 1'b0;
          end
        end
        mm160_pkg::SEQ_EMIT: begin
          if (out_free) begin
            busy <= 1'b0;
          end
        end
        default: busy <= 1'b0;
      endcase
    end
  end

endmodule

// File: tb/sv/mm160_hash_checker.sv
// ----------------------------------------------------------------------------
// mm160_hash_checker
// Watches the seed register port and both request channels of the
// five-lane MurmurHash2 engine. It keeps its own copy of the seed and of the
// lane state, works out the digest that each closing request must produce,
// and compares every digest taken from the output channel, field by field,
// against the oldest one still awaited.
// ----------------------------------------------------------------------------
module mm160_hash_checker #(
  parameter logic [2:0] SEED_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [31:0] message_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] hash_word0,
  input  logic [31:0] hash_word1,
  input  logic [31:0] hash_word2,
  input  logic [31:0] hash_word3,
  input  logic [31:0] hash_word4,
  input  logic [31:0] folded_hash,
  output int          pending,
  output int          errors
);

  localparam logic [mm160_pkg::LANES-1:0][31:0] LANE_MULT = {
    mm160_pkg::MUL4, mm160_pkg::MUL3, mm160_pkg::MUL2, mm160_pkg::MUL1, mm160_pkg::MUL0
  };
  localparam int REPORT_LIMIT = 10;

  logic [31:0]      seed_r;
  logic [31:0]      lane_r [mm160_pkg::LANES];
  logic             open_r;
  mm160_pkg::hash_t digest_q [$];
  int               error_cnt;

  function automatic bit absorb_request(input logic [31:0] word, input logic [2:0] count,
                                        input logic first, input logic last,
                                        input logic [31:0] length,
                                        output mm160_pkg::hash_t digest);
    logic [31:0] k;
    logic [31:0] tail;
    logic [31:0] v;
    int i;
    digest = '0;
    if (first) begin
      for (i = 0; i < mm160_pkg::LANES; i++) begin
        lane_r[i] = (i == 0) ? (seed_r ^ length) : (seed_r ^ length ^ LANE_MULT[i]);
      end
      open_r = 1'b1;
    end
    if (!open_r) return 1'b0;
    if (!last || count >= 3'd4) begin
      k = word * mm160_pkg::MUL0;
      k = k ^ (k >> mm160_pkg::MIX_SHIFT);
      k = k * mm160_pkg::MUL0;
      // The chain runs in place, so the last lane sees the freshly mixed first lane.
      for (i = 0; i < mm160_pkg::LANES; i++) begin
        lane_r[i] = (lane_r[i] * LANE_MULT[i]) ^ k ^ lane_r[(i + 1) % mm160_pkg::LANES];
      end
      if (!last) return 1'b0;
    end else if (count != 3'd0) begin
      tail = word & (32'hFFFF_FFFF >> (8 * (4 - count)));
      for (i = 0; i < mm160_pkg::LANES; i++) begin
        lane_r[i] = (lane_r[i] ^ tail) * LANE_MULT[i];
      end
    end
    for (i = 0; i < mm160_pkg::LANES; i++) begin
      v = lane_r[i];
      v = v ^ (v >> mm160_pkg::FIN_SHIFT_A);
      v = v * LANE_MULT[i];
      v = v ^ (v >> mm160_pkg::FIN_SHIFT_B);
      lane_r[i] = v;
    end
    open_r = 1'b0;
    digest.hash_word0 = lane_r[0] ^ lane_r[1] ^ lane_r[2] ^ lane_r[3] ^ lane_r[4];
    digest.hash_word1 = lane_r[1] ^ lane_r[0];
    digest.hash_word2 = lane_r[2] ^ lane_r[0];
    digest.hash_word3 = lane_r[3] ^ lane_r[0];
    digest.hash_word4 = lane_r[4] ^ lane_r[0];
    digest.folded_hash = digest.hash_word0 ^ digest.hash_word1 ^ digest.hash_word2 ^
                         digest.hash_word3 ^ digest.hash_word4;
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_cnt++;
      if (error_cnt <= REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %08h, got %08h", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : track_proc
    mm160_pkg::hash_t want;
    int i;
    if (rst) begin
      seed_r = '0;
      for (i = 0; i < mm160_pkg::LANES; i++) begin
        lane_r[i] = '0;
      end
      open_r = 1'b0;
      digest_q.delete();
      error_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == SEED_ADDR) begin
        seed_r = pwdata;
      end
      if (in_valid && in_ready) begin
        if (absorb_request(data_word, byte_count, first_item, last_item, message_length,
                           want)) begin
          digest_q.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= REPORT_LIMIT) begin
            $display("%0t: unexpected digest %08h on the output", $time, folded_hash);
          end
        end else begin
          want = digest_q.pop_front();
          check_field("hash_word0", want.hash_word0, hash_word0);
          check_field("hash_word1", want.hash_word1, hash_word1);
          check_field("hash_word2", want.hash_word2, hash_word2);
          check_field("hash_word3", want.hash_word3, hash_word3);
          check_field("hash_word4", want.hash_word4, hash_word4);
          check_field("folded_hash", want.folded_hash, folded_hash);
        end
      end
    end
    pending <= digest_q.size();
    errors  <= error_cnt;
  end

endmodule

// File: tb/sv/tb_murmur2_160_hash_top.sv
// ----------------------------------------------------------------------------
// tb_murmur2_160_hash_top
// Drives the five-lane MurmurHash2 engine with directed and random messages
// under several seeds, with random input gaps and output back-pressure except
// in one steady phase, and reports the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module tb_murmur2_160_hash_top;

  localparam logic [2:0] SEED_ADDR   = 3'd0;
  localparam int         IDLE_LIMIT  = 3000;
  localparam int         SETTLE_CYC  = 24;
  localparam int         PHASE_ITEMS = 185;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        first_item = 1'b0;
  logic        last_item = 1'b0;
  logic [31:0] message_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] hash_word0;
  logic [31:0] hash_word1;
  logic [31:0] hash_word2;
  logic [31:0] hash_word3;
  logic [31:0] hash_word4;
  logic [31:0] folded_hash;

  int pending;
  int errors;
  int words_sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  murmur2_160_hash_top u_top (.*);

  mm160_hash_checker #(.SEED_ADDR(SEED_ADDR)) u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(199) == 0) begin
      stall_left <= $urandom_range(10, 40);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_seed(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_word(input logic [31:0] word, input logic [2:0] count,
                           input logic first, input logic last, input logic [31:0] length);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_word      <= word;
    byte_count     <= count;
    first_item     <= first;
    last_item      <= last;
    message_length <= length;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // A closed message ends with the true tail count; an open one is abandoned
  // before its end and left for the next first request to restart.
  task automatic send_message(input int nbytes, input logic [31:0] length, input bit closed);
    int nwords;
    int idx;
    logic [2:0] count;
    bit at_end;
    nwords = (nbytes + 3) / 4;
    if (nwords == 0) nwords = 1;
    for (idx = 0; idx < nwords; idx++) begin
      at_end = closed && (idx == nwords - 1);
      if (!at_end) begin
        count = 3'($urandom_range(7));
      end else if (nbytes != 0 && nbytes % 4 == 0) begin
        count = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
      end else begin
        count = 3'(nbytes % 4);
      end
      push_word($urandom, count, idx == 0, at_end, (idx == 0) ? length : $urandom);
      words_sent++;
    end
  endtask

  task automatic random_phase(input int quota);
    int goal;
    int pick;
    int nbytes;
    logic [31:0] length;
    goal = words_sent + quota;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        nbytes = ($urandom_range(19) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 40);
        length = ($urandom_range(9) == 0) ? $urandom : 32'(nbytes);
        send_message(nbytes, length, 1'b1);
      end else if (pick < 88) begin
        send_message($urandom_range(1, 24), $urandom, 1'b0);
      end else begin
        push_word($urandom, 3'($urandom_range(7)), 1'b0, 1'($urandom_range(1)), $urandom);
      end
    end
  endtask

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_seed(32'h0000_0000);
    push_word(32'hA5A5_A5A5, 3'd4, 1'b0, 1'b0, 32'hFFFF_FFFF);
    push_word(32'hFFFF_FFFF, 3'd2, 1'b0, 1'b1, 32'h0000_0000);
    push_word(32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000);
    push_word(32'hFFFF_FFFF, 3'd3, 1'b1, 1'b1, 32'd3);
    push_word(32'h0403_0201, 3'd1, 1'b1, 1'b1, 32'd1);
    push_word(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 32'd4);
    push_word(32'h8765_4321, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_word(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0, 32'd10);
    push_word(32'h0000_0000, 3'd7, 1'b0, 1'b0, 32'hFFFF_FFFF);
    push_word(32'hFFFF_FFFF, 3'd2, 1'b0, 1'b1, 32'h0000_0000);
    push_word(32'hDEAD_BEEF, 3'd4, 1'b1, 1'b0, 32'd8);
    push_word(32'hC0FF_EE00, 3'd4, 1'b0, 1'b0, 32'h0000_0000);
    push_word(32'h1234_5678, 3'd4, 1'b1, 1'b0, 32'd5);
    push_word(32'hFFFF_FFFF, 3'd5, 1'b0, 1'b1, 32'h0000_0000);
    push_word(32'h0000_0001, 3'd4, 1'b0, 1'b1, 32'h0000_0000);
    push_word(32'h5555_AAAA, 3'd4, 1'b1, 1'b0, 32'h8000_0000);
    push_word(32'hAAAA_5555, 3'd6, 1'b0, 1'b1, 32'h7FFF_FFFF);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_seed(32'hFFFF_FFFF);
        2:       write_seed(32'h8000_0001);
        default: write_seed($urandom);
      endcase
      steady <= (phase == 2);
      if (phase == 0) begin
        push_word(32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000);
        push_word(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 32'hFFFF_FFFF);
      end
      random_phase(PHASE_ITEMS);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
